### rtl/smpq_pkg.sv
// smpq_pkg: shared constants, command codes and control structs
// for the sorted min-priority queue; no dependencies
package smpq_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int VALUE_W          = 32;
    localparam int CMD_W            = 2;
    localparam int ENTRY_COUNT_W    = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch_val;
        logic rd_tail;
        logic scan_step;
        logic wr_shift;
        logic wr_val_above;
        logic wr_val_at_idx;
        logic wr_in_at_count;
        logic count_clr;
        logic count_inc;
        logic count_dec;
        logic emit;
        logic emit_err;
        logic emit_removed;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic entry_less;
        logic idx_zero;
    } dp_status_t;

endpackage

### rtl/smpq_datapath.sv
// smpq_datapath: entry memory, count, scan pointer and result registers
// depends on smpq_pkg
module smpq_datapath #(
    parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smpq_pkg::dp_cmd_t                      cmd,
    output smpq_pkg::dp_status_t                   status,
    input  logic signed [smpq_pkg::VALUE_W-1:0]    insert_value,
    output logic                                   done,
    output logic signed [smpq_pkg::VALUE_W-1:0]    removed_value,
    output logic                                   error,
    output logic                                   is_full,
    output logic                                   is_empty,
    output logic [smpq_pkg::ENTRY_COUNT_W-1:0]     entry_count
);
    import smpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               count_m1;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               idx_m1;
    logic [AW-1:0]               idx_p1;
    logic [AW-1:0]               tail;
    logic signed [VALUE_W-1:0]   val_reg;
    logic signed [VALUE_W-1:0]   rd_data_reg;
    logic [AW-1:0]               rd_addr;
    logic                        rd_en;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [VALUE_W-1:0]          wr_data;
    logic [CW+ENTRY_COUNT_W-1:0] count_ext;

    logic                        done_reg;
    logic signed [VALUE_W-1:0]   removed_reg;
    logic                        error_reg;
    logic                        full_reg;
    logic                        empty_reg;
    logic [ENTRY_COUNT_W-1:0]    entry_count_reg;

    assign count_m1  = count_reg - CW'(1);
    assign tail      = count_m1[AW-1:0];
    assign idx_m1    = idx_reg - AW'(1);
    assign idx_p1    = idx_reg + AW'(1);
    assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count_next};

    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CW'(CAPACITY));
    assign status.entry_less = (rd_data_reg < val_reg);
    assign status.idx_zero   = (idx_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_clr)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_m1;
        end
    end

    always_comb
    begin
        rd_en   = cmd.rd_tail | cmd.scan_step;
        rd_addr = cmd.rd_tail ? tail : idx_m1;
        wr_en   = cmd.wr_shift | cmd.wr_val_above | cmd.wr_val_at_idx | cmd.wr_in_at_count;
        wr_addr = idx_p1;
        wr_data = val_reg;
        if (cmd.wr_shift)
        begin
            wr_data = rd_data_reg;
        end
        else if (cmd.wr_val_at_idx)
        begin
            wr_addr = idx_reg;
        end
        else if (cmd.wr_in_at_count)
        begin
            wr_addr = count_reg[AW-1:0];
            wr_data = insert_value;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_val)
        begin
            val_reg <= insert_value;
        end
        if (cmd.rd_tail)
        begin
            idx_reg <= tail;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_m1;
        end
        if (cmd.emit)
        begin
            removed_reg     <= cmd.emit_removed ? rd_data_reg : '0;
            error_reg       <= cmd.emit_err;
            full_reg        <= (count_next == CW'(CAPACITY));
            empty_reg       <= (count_next == '0);
            entry_count_reg <= count_ext[ENTRY_COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.emit;
        end
    end

    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign error         = error_reg;
    assign is_full       = full_reg;
    assign is_empty      = empty_reg;
    assign entry_count   = entry_count_reg;

endmodule

### rtl/smpq_ctrl.sv
// smpq_ctrl: command sequencer for clear, remove and the insert shift scan
// depends on smpq_pkg
module smpq_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [smpq_pkg::CMD_W-1:0]   command,
    output logic                         busy,
    output smpq_pkg::dp_cmd_t            cmd,
    input  smpq_pkg::dp_status_t         status
);
    import smpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            cmd.count_clr = 1'b1;
                            cmd.emit      = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            if (status.count_zero)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.emit_err = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_tail   = 1'b1;
                                cmd.count_dec = 1'b1;
                                state_next    = S_REM_OUT;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (status.count_full)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.emit_err = 1'b1;
                            end
                            else if (status.count_zero)
                            begin
                                cmd.wr_in_at_count = 1'b1;
                                cmd.count_inc      = 1'b1;
                                cmd.emit           = 1'b1;
                            end
                            else
                            begin
                                cmd.latch_val = 1'b1;
                                cmd.rd_tail   = 1'b1;
                                state_next    = S_INS_CMP;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_CMP:
            begin
                if (status.entry_less)
                begin
                    cmd.wr_shift = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_val_above = 1'b1;
                    cmd.count_inc    = 1'b1;
                    cmd.emit         = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_val_at_idx = 1'b1;
                cmd.count_inc     = 1'b1;
                cmd.emit          = 1'b1;
                state_next        = S_IDLE;
            end
            S_REM_OUT:
            begin
                cmd.emit         = 1'b1;
                cmd.emit_removed = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/sorted_min_priority_queue.sv
// sorted_min_priority_queue: min-priority queue kept as a descending array in one memory
// clear, no-op, refused and empty-queue insert commands answer in the cycle after start; remove
// reads the tail, then answers from S_REM_OUT; insert moves each smaller entry up in S_INS_CMP
// the insert scan reads and writes one entry per cycle through the memory's single ports
// busy stays high until the word is issued; the receiver cannot stall the done strobe
// reset empties the queue at once; entry contents are not cleared
module sorted_min_priority_queue #(
    parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [smpq_pkg::CMD_W-1:0]             command,
    input  logic signed [smpq_pkg::VALUE_W-1:0]    insert_value,
    output logic                                   done,
    output logic signed [smpq_pkg::VALUE_W-1:0]    removed_value,
    output logic                                   error,
    output logic                                   is_full,
    output logic                                   is_empty,
    output logic [smpq_pkg::ENTRY_COUNT_W-1:0]     entry_count
);
    import smpq_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    smpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .cmd     (dp_cmd),
        .status  (dp_status)
    );

    smpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .insert_value  (insert_value),
        .done          (done),
        .removed_value (removed_value),
        .error         (error),
        .is_full       (is_full),
        .is_empty      (is_empty),
        .entry_count   (entry_count)
    );

endmodule

### rtl/smpq_checker.sv
// smpq_checker: port-level checks on the result words of the queue
// depends on smpq_pkg; bound to sorted_min_priority_queue
module smpq_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [smpq_pkg::CMD_W-1:0]             command,
    input  logic                                   done,
    input  logic signed [smpq_pkg::VALUE_W-1:0]    removed_value,
    input  logic                                   error,
    input  logic                                   is_full,
    input  logic                                   is_empty,
    input  logic [smpq_pkg::ENTRY_COUNT_W-1:0]     entry_count
);
    import smpq_pkg::*;

    a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_CLEAR |=>
            done && is_empty && !error && entry_count == '0 && removed_value == '0)
        else $error("clear did not give an empty word");

    a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_full && is_empty))
        else $error("full and empty together");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && error |-> removed_value == '0)
        else $error("refused command returned a value");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_empty |-> entry_count == '0)
        else $error("empty flag with nonzero count");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .done          (done),
    .removed_value (removed_value),
    .error         (error),
    .is_full       (is_full),
    .is_empty      (is_empty),
    .entry_count   (entry_count)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking regression for sorted_min_priority_queue, directed corners then
// random command mixes, every word checked against an in-bench shadow of the sorted store
// depends on smpq_pkg and sorted_min_priority_queue
module testbench;

    import smpq_pkg::*;

    localparam int QCAP         = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = QCAP + 16;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed;
        logic                      err;
        logic                      full;
        logic                      empty;
        logic [ENTRY_COUNT_W-1:0]  count;
    } outcome_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [CMD_W-1:0]           command = CMD_NOP;
    logic signed [VALUE_W-1:0]  insert_value = '0;
    logic                       busy;
    logic                       done;
    logic signed [VALUE_W-1:0]  removed_value;
    logic                       error;
    logic                       is_full;
    logic                       is_empty;
    logic [ENTRY_COUNT_W-1:0]   entry_count;

    logic signed [VALUE_W-1:0]  sorted_shadow [QCAP];
    int                         shadow_count = 0;
    outcome_t                   expected_words [$];
    int                         fault_count = 0;
    int                         cycle_count = 0;
    bit                         idle_on = 1'b1;

    sorted_min_priority_queue #(
        .CAPACITY(QCAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .insert_value (insert_value),
        .done         (done),
        .removed_value(removed_value),
        .error        (error),
        .is_full      (is_full),
        .is_empty     (is_empty),
        .entry_count  (entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_min_priority_queue regression: fail");
            $finish;
        end
    end

    function automatic outcome_t predict_outcome(input logic [CMD_W-1:0] cmd,
                                                 input logic signed [VALUE_W-1:0] val);
        outcome_t o;
        int       pos;
        o = '0;
        case (cmd)
            CMD_CLEAR:
                shadow_count = 0;
            CMD_REMOVE:
                if (shadow_count == 0)
                    o.err = 1'b1;
                else
                begin
                    shadow_count = shadow_count - 1;
                    o.removed = sorted_shadow[shadow_count];
                end
            CMD_INSERT:
                if (shadow_count >= QCAP)
                    o.err = 1'b1;
                else
                begin
                    // new value goes after every entry greater than or equal to it
                    pos = shadow_count;
                    for (int k = 0; k < shadow_count; k++)
                        if (val > sorted_shadow[k])
                        begin
                            pos = k;
                            break;
                        end
                    for (int k = shadow_count; k > pos; k--)
                        sorted_shadow[k] = sorted_shadow[k-1];
                    sorted_shadow[pos] = val;
                    shadow_count = shadow_count + 1;
                end
            default:
                ;
        endcase
        o.full  = (shadow_count == QCAP);
        o.empty = (shadow_count == 0);
        o.count = ENTRY_COUNT_W'(shadow_count);
        return o;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin : check_words
        outcome_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
                note_fault("result word with nothing outstanding");
            else
            begin
                want = expected_words.pop_front();
                if (removed_value !== want.removed)
                    note_fault($sformatf("removed_value expected %h got %h",
                                         want.removed, removed_value));
                if (error !== want.err)
                    note_fault($sformatf("error expected %b got %b", want.err, error));
                if (is_full !== want.full)
                    note_fault($sformatf("is_full expected %b got %b", want.full, is_full));
                if (is_empty !== want.empty)
                    note_fault($sformatf("is_empty expected %b got %b",
                                         want.empty, is_empty));
                if (entry_count !== want.count)
                    note_fault($sformatf("entry_count expected %0d got %0d",
                                         want.count, entry_count));
            end
        end
    end

    task automatic pause_sender(input int cycles);
        start        <= 1'b0;
        command      <= CMD_W'($urandom);
        insert_value <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        start        <= 1'b1;
        command      <= cmd;
        insert_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_words.push_back(predict_outcome(cmd, val));
        if (idle_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 15));
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        else if (sel < 8)
            return VALUE_W'($signed($urandom_range(0, 16)) - 8);
        else
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return '0;
                default: return '1;
            endcase
    endfunction

    task automatic test_corner_values();
        send_word(CMD_REMOVE, $urandom);
        send_word(CMD_NOP, $urandom);
        send_word(CMD_CLEAR, $urandom);
        send_word(CMD_INSERT, VAL_MAX);
        send_word(CMD_INSERT, VAL_MIN);
        send_word(CMD_INSERT, '0);
        send_word(CMD_INSERT, '1);
        send_word(CMD_INSERT, 32'd1);
        send_word(CMD_INSERT, '0);
        send_word(CMD_NOP, $urandom);
        repeat (6) send_word(CMD_REMOVE, $urandom);
        send_word(CMD_REMOVE, $urandom);
        send_word(CMD_INSERT, 32'd5);
        send_word(CMD_INSERT, -32'sd5);
        send_word(CMD_CLEAR, $urandom);
        send_word(CMD_REMOVE, $urandom);
        send_word(CMD_INSERT, 32'haaaa_aaaa);
        send_word(CMD_INSERT, 32'h5555_5555);
        send_word(CMD_REMOVE, $urandom);
        send_word(CMD_REMOVE, $urandom);
    endtask

    task automatic test_fill_and_drain();
        send_word(CMD_CLEAR, $urandom);
        repeat (QCAP) send_word(CMD_INSERT, pick_value());
        repeat (3) send_word(CMD_INSERT, pick_value());
        send_word(CMD_NOP, $urandom);
        repeat (QCAP) send_word(CMD_REMOVE, $urandom);
        repeat (2) send_word(CMD_REMOVE, $urandom);
    endtask

    task automatic test_random_mix(input int words, input int insert_pct,
                                   input int remove_pct, input bit allow_idle);
        int               r;
        logic [CMD_W-1:0] cmd;
        for (int n = 0; n < words; n++)
        begin
            // decide anew for each stretch of 32 words whether it has sender gaps
            if (n % 32 == 0)
                idle_on = allow_idle && ($urandom_range(0, 2) != 0);
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                cmd = CMD_INSERT;
            else if (r < insert_pct + remove_pct)
                cmd = CMD_REMOVE;
            else if (r < insert_pct + remove_pct + 2)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_NOP;
            send_word(cmd, (cmd == CMD_INSERT) ? pick_value() : VALUE_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        test_fill_and_drain();
        test_random_mix(400, 70, 24, 1'b1);
        test_random_mix(400, 47, 47, 1'b1);
        test_random_mix(300, 30, 64, 1'b1);
        idle_on = 1'b0;
        test_random_mix(250, 50, 44, 1'b0);

        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("sorted_min_priority_queue regression: pass");
        else
            $display("sorted_min_priority_queue regression: fail");
        $finish;
    end

endmodule
